FILE: design/i2c_master_register_access_top_assert.svh
// ----------------------------------------------------------------------------
// I2C master register access - assertion macros
// Shared concurrent assertion forms for the register access block.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I2CM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm same-cycle check failed");

// next-cycle implication, disabled in reset
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm next-cycle check failed");

`endif

FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access - package
// Item types, configuration types, codes and reset values.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_LIMIT   = 1'b1;

   localparam logic [9:0] PHASE_TICKS_RESET = 10'd21;
   localparam logic [7:0] ACK_LIMIT_RESET   = 8'd50;
   localparam logic [7:0] MSB_MASK          = 8'h80;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] device_address;
      logic [7:0] register_index;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       write_taken;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       ack_missed;
      logic       done_res;
   } rsp_item_type;

   typedef struct packed {
      logic [9:0] phase_ticks;
      logic [7:0] ack_wait_limit;
   } cfg_type;

   typedef enum logic [18:0] {
      PH_IDLE    = 19'h00001,
      PH_ST_A    = 19'h00002,
      PH_ST_B    = 19'h00004,
      PH_ST_C    = 19'h00008,
      PH_TX_LO   = 19'h00010,
      PH_TX_HI   = 19'h00020,
      PH_AK_LO   = 19'h00040,
      PH_AK_HI   = 19'h00080,
      PH_AK_POLL = 19'h00100,
      PH_AK_END  = 19'h00200,
      PH_RX_SET  = 19'h00400,
      PH_RX_HI   = 19'h00800,
      PH_RX_LO   = 19'h01000,
      PH_MA_LO   = 19'h02000,
      PH_MA_HI   = 19'h04000,
      PH_MA_END  = 19'h08000,
      PH_SP_A    = 19'h10000,
      PH_SP_B    = 19'h20000,
      PH_SP_C    = 19'h40000
   } phase_type;

   typedef enum logic [1:0] {
      STG_ADDR_WR = 2'd0,
      STG_REG     = 2'd1,
      STG_DATA    = 2'd2,
      STG_ADDR_RD = 2'd3
   } stage_type;

endpackage

FILE: design/i2c_master_register_access_top.sv
// One item per clock cycle, sustained while the result side does not stall.
// Each item is one bus tick: it lands in the input register, the sequencer
// applies one step of the transaction state machine to it, and the result
// item is held in the output register. The sequencer state updates in a
// single step per item, which sets this rate; a stall on the result side
// holds the input side only once both registers are occupied.
// ----------------------------------------------------------------------------
// I2C master register access - top level
// Input and result registers around the bus sequencer and its configuration.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [9:0]   csr_data
);

`include "i2c_master_register_access_top_assert.svh"

   cfg_type      cfg;
   rsp_item_type step_result;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         advance;
   logic         req_accept;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `I2CM_ASSERT_NEXT(a_advance_loads_result, clock, reset, advance, out_valid_ff)
   `I2CM_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall,
                      in_valid_ff && out_valid_ff)
   `I2CM_ASSERT_IMPLY(a_read_while_busy, clock, reset,
                      out_valid_ff && out_item_ff.read_valid,
                      out_item_ff.busy_res && out_item_ff.scl_level)
   `I2CM_ASSERT_IMPLY(a_done_releases_bus, clock, reset,
                      out_valid_ff && out_item_ff.done_res,
                      out_item_ff.scl_level && !out_item_ff.sda_pull_low)

endmodule

FILE: design/i2cm_csr.sv
// ----------------------------------------------------------------------------
// I2C master register access - configuration registers
// Holds phase length and acknowledge poll limit.
// ----------------------------------------------------------------------------
module i2cm_csr
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [9:0] csr_data,
   output cfg_type    cfg
);

   logic [9:0] phase_ticks_ff;
   logic [9:0] phase_ticks_in;
   logic [7:0] ack_limit_ff;
   logic [7:0] ack_limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      ack_limit_in   = ack_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_TICKS: phase_ticks_in = csr_data;
            CSR_ACK_LIMIT:   ack_limit_in   = csr_data[7:0];
            default:         phase_ticks_in = phase_ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_limit_ff   <= ACK_LIMIT_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
         ack_limit_ff   <= ack_limit_in;
      end
   end

   assign cfg.phase_ticks    = phase_ticks_ff;
   assign cfg.ack_wait_limit = ack_limit_ff;

endmodule

FILE: design/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master register access - bus sequencer
// One tick of the transaction state machine per advanced item.
// ----------------------------------------------------------------------------
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   phase_type  phase_ff, phase_in;
   stage_type  stage_ff, stage_in;
   logic [9:0] tick_ff, tick_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] ack_polls_ff, ack_polls_in;
   logic       ack_fail_ff, ack_fail_in;
   logic [7:0] held_address_ff, held_address_in;
   logic [7:0] held_register_ff, held_register_in;
   logic       is_read_ff, is_read_in;

   logic [9:0]  ticks_eff;
   logic [7:0]  limit_eff;
   logic [10:0] tick_sum;
   logic        last;
   logic [3:0]  bit_inc;
   logic [7:0]  polls_inc;
   logic [7:0]  rx_shift;

   assign ticks_eff = (cfg.phase_ticks == '0) ? 10'd1 : cfg.phase_ticks;
   assign limit_eff = (cfg.ack_wait_limit == '0) ? 8'd1 : cfg.ack_wait_limit;
   assign tick_sum  = {1'b0, tick_ff} + 11'd1;
   assign last      = (tick_sum >= {1'b0, ticks_eff});
   assign bit_inc   = bit_count_ff + 4'd1;
   assign polls_inc = ack_polls_ff + 8'd1;
   assign rx_shift  = {shift_ff[6:0], item.sda_in};

   always_comb begin
      phase_in         = phase_ff;
      stage_in         = stage_ff;
      tick_in          = tick_ff;
      bit_count_in     = bit_count_ff;
      bytes_left_in    = bytes_left_ff;
      shift_in         = shift_ff;
      ack_polls_in     = ack_polls_ff;
      ack_fail_in      = ack_fail_ff;
      held_address_in  = held_address_ff;
      held_register_in = held_register_ff;
      is_read_in       = is_read_ff;
      result           = '0;
      result.scl_level = 1'b1;
      result.busy_res  = 1'b1;

      if (phase_ff != PH_IDLE && phase_ff != PH_AK_POLL) begin
         tick_in = last ? '0 : tick_sum[9:0];
      end

      case (phase_ff)
         PH_IDLE: begin
            result.busy_res = 1'b0;
            if (item.operation inside {OP_WRITE, OP_READ}) begin
               result.busy_res  = 1'b1;
               held_address_in  = item.device_address;
               held_register_in = item.register_index;
               bytes_left_in    = item.byte_count;
               is_read_in       = (item.operation == OP_READ);
               ack_fail_in      = 1'b0;
               stage_in         = STG_ADDR_WR;
               phase_in         = PH_ST_A;
               tick_in          = '0;
            end
         end
         PH_ST_A: begin
            if (last) begin
               phase_in = PH_ST_B;
            end
         end
         PH_ST_B: begin
            result.sda_pull_low = 1'b1;
            if (last) begin
               phase_in = PH_ST_C;
            end
         end
         PH_ST_C: begin
            result.scl_level    = 1'b0;
            result.sda_pull_low = 1'b1;
            if (last) begin
               shift_in     = (stage_ff == STG_ADDR_RD) ? {held_address_ff[7:1], 1'b1}
                                                        : {held_address_ff[7:1], 1'b0};
               bit_count_in = '0;
               phase_in     = PH_TX_LO;
            end
         end
         PH_TX_LO, PH_TX_HI: begin
            result.scl_level    = (phase_ff == PH_TX_HI);
            result.sda_pull_low = ((shift_ff & MSB_MASK) == '0);
            if (last) begin
               if (phase_ff == PH_TX_LO) begin
                  phase_in = PH_TX_HI;
               end else begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_inc;
                  phase_in     = (bit_inc >= 4'd8) ? PH_AK_LO : PH_TX_LO;
               end
            end
         end
         PH_AK_LO: begin
            result.scl_level = 1'b0;
            if (last) begin
               phase_in = PH_AK_HI;
            end
         end
         PH_AK_HI: begin
            if (last) begin
               ack_polls_in = '0;
               phase_in     = PH_AK_POLL;
            end
         end
         PH_AK_POLL: begin
            if (!item.sda_in) begin
               phase_in = PH_AK_END;
               tick_in  = '0;
            end else begin
               ack_polls_in = polls_inc;
               if (polls_inc >= limit_eff || polls_inc == '0) begin
                  ack_fail_in = 1'b1;
                  phase_in    = PH_AK_END;
                  tick_in     = '0;
               end
            end
         end
         PH_AK_END: begin
            result.scl_level = 1'b0;
            if (last) begin
               if (stage_ff == STG_ADDR_WR) begin
                  stage_in     = STG_REG;
                  shift_in     = held_register_ff;
                  bit_count_in = '0;
                  phase_in     = PH_TX_LO;
               end else if (stage_ff == STG_REG && is_read_ff) begin
                  stage_in = STG_ADDR_RD;
                  phase_in = PH_ST_A;
               end else if (stage_ff == STG_ADDR_RD) begin
                  if (bytes_left_ff == '0) begin
                     phase_in = PH_SP_A;
                  end else begin
                     shift_in     = '0;
                     bit_count_in = '0;
                     phase_in     = PH_RX_SET;
                  end
               end else begin
                  stage_in = STG_DATA;
                  if (bytes_left_ff == '0) begin
                     phase_in = PH_SP_A;
                  end else begin
                     result.write_taken = 1'b1;
                     bytes_left_in      = bytes_left_ff - 8'd1;
                     shift_in           = item.write_byte;
                     bit_count_in       = '0;
                     phase_in           = PH_TX_LO;
                  end
               end
            end
         end
         PH_RX_SET: begin
            result.scl_level = 1'b0;
            if (last) begin
               phase_in = PH_RX_HI;
            end
         end
         PH_RX_HI: begin
            if (last) begin
               shift_in     = rx_shift;
               bit_count_in = bit_inc;
               if (bit_inc >= 4'd8) begin
                  result.read_byte  = rx_shift;
                  result.read_valid = 1'b1;
               end
               phase_in = PH_RX_LO;
            end
         end
         PH_RX_LO: begin
            result.scl_level = 1'b0;
            if (last) begin
               if (bit_count_ff >= 4'd8) begin
                  bytes_left_in = bytes_left_ff - 8'd1;
                  phase_in      = PH_MA_LO;
               end else begin
                  phase_in = PH_RX_HI;
               end
            end
         end
         PH_MA_LO, PH_MA_HI, PH_MA_END: begin
            result.scl_level    = (phase_ff == PH_MA_HI);
            result.sda_pull_low = (bytes_left_ff != '0);
            if (last) begin
               if (phase_ff == PH_MA_LO) begin
                  phase_in = PH_MA_HI;
               end else if (phase_ff == PH_MA_HI) begin
                  phase_in = PH_MA_END;
               end else if (bytes_left_ff == '0) begin
                  phase_in = PH_SP_A;
               end else begin
                  shift_in     = '0;
                  bit_count_in = '0;
                  phase_in     = PH_RX_SET;
               end
            end
         end
         PH_SP_A: begin
            result.scl_level    = 1'b0;
            result.sda_pull_low = 1'b1;
            if (last) begin
               phase_in = PH_SP_B;
            end
         end
         PH_SP_B: begin
            result.sda_pull_low = 1'b1;
            if (last) begin
               phase_in = PH_SP_C;
            end
         end
         PH_SP_C: begin
            if (last) begin
               result.done_res = 1'b1;
               phase_in        = PH_IDLE;
            end
         end
         default: begin
            result.busy_res = 1'b0;
            phase_in        = PH_IDLE;
            tick_in         = '0;
         end
      endcase

      result.ack_missed = ack_fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         stage_ff         <= STG_ADDR_WR;
         tick_ff          <= '0;
         bit_count_ff     <= '0;
         bytes_left_ff    <= '0;
         shift_ff         <= '0;
         ack_polls_ff     <= '0;
         ack_fail_ff      <= 1'b0;
         held_address_ff  <= '0;
         held_register_ff <= '0;
         is_read_ff       <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         stage_ff         <= stage_in;
         tick_ff          <= tick_in;
         bit_count_ff     <= bit_count_in;
         bytes_left_ff    <= bytes_left_in;
         shift_ff         <= shift_in;
         ack_polls_ff     <= ack_polls_in;
         ack_fail_ff      <= ack_fail_in;
         held_address_ff  <= held_address_in;
         held_register_ff <= held_register_in;
         is_read_ff       <= is_read_in;
      end
   end

endmodule

FILE: verif/i2c_master_register_access_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access - bus checker
// Watches the tick, result and CSR channels. Each accepted tick is run
// through a local copy of the bus sequencer, and the pin levels and flags it
// yields are queued. Each accepted result is compared with the oldest entry.
// ----------------------------------------------------------------------------
module i2c_master_register_access_checker
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_index,
   input  logic [9:0]   csr_data,
   output int           mismatch_count,
   output int           pending_count
);

   cfg_type      cfg;
   phase_type    phase;
   stage_type    stage;
   logic [9:0]   tick_count;
   logic [3:0]   bit_count;
   logic [7:0]   bytes_left;
   logic [7:0]   shift_reg;
   logic [7:0]   ack_polls;
   logic         ack_fail;
   logic [7:0]   held_address;
   logic [7:0]   held_register;
   logic         is_read;

   rsp_item_type pins_due[$];
   rsp_item_type want;
   int           rsp_seen;

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] exp_val);
      if (got !== exp_val) begin
         report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                   rsp_seen, name, got, exp_val));
      end
   endtask

   function automatic void enter(input phase_type nxt);
      phase = nxt;
      tick_count = '0;
   endfunction

   function automatic void load_byte(input logic [7:0] b);
      shift_reg = b;
      bit_count = '0;
      enter(PH_TX_LO);
   endfunction

   function automatic rsp_item_type advance_bus(input req_item_type t);
      rsp_item_type r;
      logic [9:0]   span;
      logic [7:0]   lim;
      logic [10:0]  nxt;
      logic         last;
      r = '0;
      r.scl_level = 1'b1;
      r.busy_res = 1'b1;
      last = 1'b0;
      span = (cfg.phase_ticks == '0) ? 10'd1 : cfg.phase_ticks;
      lim = (cfg.ack_wait_limit == '0) ? 8'd1 : cfg.ack_wait_limit;
      if (phase != PH_IDLE && phase != PH_AK_POLL) begin
         nxt = {1'b0, tick_count} + 11'd1;
         last = (nxt >= {1'b0, span});
         tick_count = last ? 10'd0 : nxt[9:0];
      end
      case (phase)
         PH_IDLE: begin
            r.busy_res = 1'b0;
            if (t.operation == OP_WRITE || t.operation == OP_READ) begin
               r.busy_res = 1'b1;
               held_address = t.device_address;
               held_register = t.register_index;
               bytes_left = t.byte_count;
               is_read = (t.operation == OP_READ);
               ack_fail = 1'b0;
               stage = STG_ADDR_WR;
               enter(PH_ST_A);
            end
         end
         PH_ST_A: begin
            if (last) enter(PH_ST_B);
         end
         PH_ST_B: begin
            r.sda_pull_low = 1'b1;
            if (last) enter(PH_ST_C);
         end
         PH_ST_C: begin
            r.scl_level = 1'b0;
            r.sda_pull_low = 1'b1;
            if (last) begin
               load_byte(stage == STG_ADDR_RD ? (held_address | 8'h01)
                                              : (held_address & 8'hFE));
            end
         end
         PH_TX_LO, PH_TX_HI: begin
            r.scl_level = (phase == PH_TX_HI);
            r.sda_pull_low = ((shift_reg & MSB_MASK) == '0);
            if (last) begin
               if (phase == PH_TX_LO) begin
                  enter(PH_TX_HI);
               end else begin
                  shift_reg = shift_reg << 1;
                  bit_count = bit_count + 4'd1;
                  enter(bit_count >= 4'd8 ? PH_AK_LO : PH_TX_LO);
               end
            end
         end
         PH_AK_LO: begin
            r.scl_level = 1'b0;
            if (last) enter(PH_AK_HI);
         end
         PH_AK_HI: begin
            if (last) begin
               ack_polls = '0;
               enter(PH_AK_POLL);
            end
         end
         PH_AK_POLL: begin
            if (!t.sda_in) begin
               enter(PH_AK_END);
            end else begin
               ack_polls = ack_polls + 8'd1;
               if (ack_polls >= lim || ack_polls == '0) begin
                  ack_fail = 1'b1;
                  enter(PH_AK_END);
               end
            end
         end
         PH_AK_END: begin
            r.scl_level = 1'b0;
            if (last) begin
               if (stage == STG_ADDR_WR) begin
                  stage = STG_REG;
                  load_byte(held_register);
               end else if (stage == STG_REG && is_read) begin
                  stage = STG_ADDR_RD;
                  enter(PH_ST_A);
               end else if (stage == STG_ADDR_RD) begin
                  if (bytes_left == '0) begin
                     enter(PH_SP_A);
                  end else begin
                     shift_reg = '0;
                     bit_count = '0;
                     enter(PH_RX_SET);
                  end
               end else begin
                  stage = STG_DATA;
                  if (bytes_left == '0) begin
                     enter(PH_SP_A);
                  end else begin
                     r.write_taken = 1'b1;
                     bytes_left = bytes_left - 8'd1;
                     load_byte(t.write_byte);
                  end
               end
            end
         end
         PH_RX_SET: begin
            r.scl_level = 1'b0;
            if (last) enter(PH_RX_HI);
         end
         PH_RX_HI: begin
            if (last) begin
               shift_reg = {shift_reg[6:0], t.sda_in};
               bit_count = bit_count + 4'd1;
               if (bit_count >= 4'd8) begin
                  r.read_byte = shift_reg;
                  r.read_valid = 1'b1;
               end
               enter(PH_RX_LO);
            end
         end
         PH_RX_LO: begin
            r.scl_level = 1'b0;
            if (last) begin
               if (bit_count >= 4'd8) begin
                  bytes_left = bytes_left - 8'd1;
                  enter(PH_MA_LO);
               end else begin
                  enter(PH_RX_HI);
               end
            end
         end
         PH_MA_LO, PH_MA_HI, PH_MA_END: begin
            r.scl_level = (phase == PH_MA_HI);
            r.sda_pull_low = (bytes_left != '0);
            if (last) begin
               if (phase == PH_MA_LO) begin
                  enter(PH_MA_HI);
               end else if (phase == PH_MA_HI) begin
                  enter(PH_MA_END);
               end else if (bytes_left == '0) begin
                  enter(PH_SP_A);
               end else begin
                  shift_reg = '0;
                  bit_count = '0;
                  enter(PH_RX_SET);
               end
            end
         end
         PH_SP_A: begin
            r.scl_level = 1'b0;
            r.sda_pull_low = 1'b1;
            if (last) enter(PH_SP_B);
         end
         PH_SP_B: begin
            r.sda_pull_low = 1'b1;
            if (last) enter(PH_SP_C);
         end
         PH_SP_C: begin
            if (last) begin
               r.done_res = 1'b1;
               enter(PH_IDLE);
            end
         end
         default: begin
            r.busy_res = 1'b0;
            enter(PH_IDLE);
         end
      endcase
      r.ack_missed = ack_fail;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = {PHASE_TICKS_RESET, ACK_LIMIT_RESET};
         phase = PH_IDLE;
         stage = STG_ADDR_WR;
         tick_count = '0;
         bit_count = '0;
         bytes_left = '0;
         shift_reg = '0;
         ack_polls = '0;
         ack_fail = 1'b0;
         held_address = '0;
         held_register = '0;
         is_read = 1'b0;
         pins_due.delete();
         rsp_seen = 0;
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PHASE_TICKS) cfg.phase_ticks = csr_data;
            else cfg.ack_wait_limit = csr_data[7:0];
         end
         if (req_valid && !req_stall) pins_due.push_back(advance_bus(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (pins_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none due", rsp_seen));
            end else begin
               want = pins_due.pop_front();
               check_field("scl_level", rsp_item.scl_level, want.scl_level);
               check_field("sda_pull_low", rsp_item.sda_pull_low, want.sda_pull_low);
               check_field("busy_res", rsp_item.busy_res, want.busy_res);
               check_field("write_taken", rsp_item.write_taken, want.write_taken);
               check_field("read_byte", rsp_item.read_byte, want.read_byte);
               check_field("read_valid", rsp_item.read_valid, want.read_valid);
               check_field("ack_missed", rsp_item.ack_missed, want.ack_missed);
               check_field("done_res", rsp_item.done_res, want.done_res);
            end
            rsp_seen++;
         end
      end
      pending_count <= pins_due.size();
   end

endmodule

FILE: verif/i2c_master_register_access_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access - testbench top
// Drives bus ticks and CSR writes into the block through several phase and
// ack-limit settings, with random tick idling and result stalls in all but
// the last two, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top_tb;
   import i2cm_pkg::*;

   localparam int NUM_SETTINGS = 7;
   localparam logic [9:0] PHASE_TICKS_SET [NUM_SETTINGS] =
      '{10'd1, 10'd21, 10'd2, 10'd0, 10'd1023, 10'd3, 10'd1};
   localparam logic [9:0] ACK_LIMIT_SET [NUM_SETTINGS] =
      '{10'd1, 10'd50, 10'h3FF, 10'd0, 10'd255, 10'h102, 10'd3};
   localparam int TICKS_PER_SETTING [NUM_SETTINGS] =
      '{300, 150, 300, 250, 150, 300, 300};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_PHASE_TICKS;
   logic [9:0]   csr_data = '0;
   int           mismatch_count;
   int           pending_count;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   i2c_master_register_access_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   i2c_master_register_access_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic write_csr(input logic idx, input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drive_tick(input req_item_type t);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_item_type random_tick();
      req_item_type t;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) t.operation = OP_TICK;
      else if (pick < 89) t.operation = OP_WRITE;
      else if (pick < 98) t.operation = OP_READ;
      else t.operation = OP_WRITE | OP_READ;
      t.device_address = 8'($urandom_range(0, 255));
      t.register_index = 8'($urandom_range(0, 255));
      t.byte_count = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 3));
      t.write_byte = 8'($urandom_range(0, 255));
      t.sda_in = ($urandom_range(0, 99) < 30);
      return t;
   endfunction

   initial begin
      int setting;
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting < 3) begin
            send_idle_pct = 25;
            recv_stall_pct = 49;
         end else if (setting < 5) begin
            send_idle_pct = 49;
            recv_stall_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_csr(CSR_PHASE_TICKS, PHASE_TICKS_SET[setting]);
         write_csr(CSR_ACK_LIMIT, ACK_LIMIT_SET[setting]);
         csr_valid <= 1'b0;
         if (setting == 0) begin
            drive_tick('{OP_WRITE | OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
            drive_tick('{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
            drive_tick('{OP_WRITE, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1});
            for (i = 0; i < 20; i++) begin
               drive_tick('{OP_READ, 8'h00, 8'hFF, 8'hFF, 8'h00, i[0]});
            end
         end
         repeat (TICKS_PER_SETTING[setting]) drive_tick(random_tick());
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while (pending_count != 0);
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
